// ===== rtl/cmuv_pkg.sv =====
package cmuv_pkg;

    // Signed input coordinate width and number of fraction bits in u and v.
    localparam int COORD_WIDTH  = 24;
    localparam int UV_FRAC_BITS = 16;

    // The partial remainder holds the numerator uc + max, which reaches 2 * max.
    localparam int REM_WIDTH = COORD_WIDTH + 1;

    // Stream data widths, padded to whole bytes.
    localparam int S_TDATA_WIDTH = ((3 * COORD_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_WIDTH = ((2 * UV_FRAC_BITS + 7) / 8) * 8;

    // One half and the saturated full-scale code.
    localparam logic [UV_FRAC_BITS-1:0] UV_HALF = UV_FRAC_BITS'(1) << (UV_FRAC_BITS - 1);
    localparam logic [UV_FRAC_BITS-1:0] UV_TOP  = '1;

    // Work carried from cell to cell along the divider chain.
    typedef struct packed {
        logic [COORD_WIDTH-1:0]  mag;
        logic [REM_WIDTH-1:0]    rem_u;
        logic [REM_WIDTH-1:0]    rem_v;
        logic [UV_FRAC_BITS-1:0] quo_u;
        logic [UV_FRAC_BITS-1:0] quo_v;
        logic                    sat_u;
        logic                    sat_v;
        logic                    zero;
    } stage_t;

endpackage

// ===== rtl/cube_map_uv_projection.sv =====
// Channel  Direction  Handshake          Payload
// s_axis   in         s_tvalid/s_tready  s_tdata: pos_x, pos_y, pos_z
// m_axis   out        m_tvalid/m_tready  m_tdata: u_coord, v_coord; m_tuser: zero_vector
//
// One vertex is taken every cycle while no stall at m_tready holds the chain; the front
// register is followed by the divider chain, one quotient bit per cell.
// rst_n clears all valid flags asynchronously; payload registers are not reset.
// Each stage holds while the stage after it is full and stalled; empty stages
// still move, so a stall at m_tready reaches s_tready only once the chain fills.
module cube_map_uv_projection
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [cmuv_pkg::S_TDATA_WIDTH-1:0] s_tdata,  // pos_x, pos_y, pos_z
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [cmuv_pkg::M_TDATA_WIDTH-1:0] m_tdata,  // u_coord, v_coord
    output logic                               m_tuser   // zero_vector
);

    logic [cmuv_pkg::UV_FRAC_BITS:0] vld;
    logic [cmuv_pkg::UV_FRAC_BITS:0] rdy;
    cmuv_pkg::stage_t                dat [cmuv_pkg::UV_FRAC_BITS+1];
    cmuv_pkg::stage_t                last;
    logic [cmuv_pkg::UV_FRAC_BITS-1:0] u_coord;
    logic [cmuv_pkg::UV_FRAC_BITS-1:0] v_coord;

    // Face selection and numerators.
    cmuv_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .pos_x     (s_tdata[cmuv_pkg::COORD_WIDTH-1:0]),
        .pos_y     (s_tdata[2*cmuv_pkg::COORD_WIDTH-1:cmuv_pkg::COORD_WIDTH]),
        .pos_z     (s_tdata[3*cmuv_pkg::COORD_WIDTH-1:2*cmuv_pkg::COORD_WIDTH]),
        .out_valid (vld[0]),
        .out_ready (rdy[0]),
        .out_data  (dat[0])
    );

    // Chain of divider cells, one quotient bit each for u and v.
    for (genvar i = 0; i < cmuv_pkg::UV_FRAC_BITS; i++)
    begin : g_cell
        cmuv_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (vld[i]),
            .in_ready  (rdy[i]),
            .in_data   (dat[i]),
            .out_valid (vld[i+1]),
            .out_ready (rdy[i+1]),
            .out_data  (dat[i+1])
        );
    end

    assign last = dat[cmuv_pkg::UV_FRAC_BITS];

    // Final selection: origin, full-scale saturation, or the quotient.
    always_comb
    begin
        if (last.zero)
        begin
            u_coord = cmuv_pkg::UV_HALF;
            v_coord = cmuv_pkg::UV_HALF;
        end
        else
        begin
            u_coord = last.sat_u ? cmuv_pkg::UV_TOP : last.quo_u;
            v_coord = last.sat_v ? cmuv_pkg::UV_TOP : last.quo_v;
        end
    end

    assign rdy[cmuv_pkg::UV_FRAC_BITS] = m_tready;
    assign m_tvalid = vld[cmuv_pkg::UV_FRAC_BITS];
    assign m_tdata  = cmuv_pkg::M_TDATA_WIDTH'({v_coord, u_coord});
    assign m_tuser  = last.zero;

    // Input backpressure only ever comes from a stalled output.
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // The origin always reads as one half on both axes.
    a_origin_half: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (u_coord == cmuv_pkg::UV_HALF) && (v_coord == cmuv_pkg::UV_HALF))
        else $error("origin result is not one half");

endmodule

// ===== rtl/cmuv_front.sv =====
module cmuv_front
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [cmuv_pkg::COORD_WIDTH-1:0] pos_x,
    input  logic signed [cmuv_pkg::COORD_WIDTH-1:0] pos_y,
    input  logic signed [cmuv_pkg::COORD_WIDTH-1:0] pos_z,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output cmuv_pkg::stage_t                      out_data
);

    logic [cmuv_pkg::COORD_WIDTH-1:0]   abs_x;
    logic [cmuv_pkg::COORD_WIDTH-1:0]   abs_y;
    logic [cmuv_pkg::COORD_WIDTH-1:0]   abs_z;
    logic signed [cmuv_pkg::COORD_WIDTH:0] ext_x;
    logic signed [cmuv_pkg::COORD_WIDTH:0] ext_y;
    logic signed [cmuv_pkg::COORD_WIDTH:0] ext_z;
    logic signed [cmuv_pkg::COORD_WIDTH:0] uc;
    logic signed [cmuv_pkg::COORD_WIDTH:0] vc;
    logic signed [cmuv_pkg::COORD_WIDTH+1:0] num_u;
    logic signed [cmuv_pkg::COORD_WIDTH+1:0] num_v;
    logic [cmuv_pkg::COORD_WIDTH-1:0]   max_mag;
    logic                               x_dom;
    logic                               y_dom;
    logic                               z_dom;
    logic                               x_pos;
    logic                               y_pos;
    logic                               z_pos;
    cmuv_pkg::stage_t                   data_next;
    cmuv_pkg::stage_t                   data_reg;
    logic                               valid_reg;

    // Magnitudes; the most negative code maps to its exact unsigned magnitude.
    assign abs_x = pos_x[cmuv_pkg::COORD_WIDTH-1] ? (~pos_x + 1'b1) : pos_x;
    assign abs_y = pos_y[cmuv_pkg::COORD_WIDTH-1] ? (~pos_y + 1'b1) : pos_y;
    assign abs_z = pos_z[cmuv_pkg::COORD_WIDTH-1] ? (~pos_z + 1'b1) : pos_z;

    assign ext_x = {pos_x[cmuv_pkg::COORD_WIDTH-1], pos_x};
    assign ext_y = {pos_y[cmuv_pkg::COORD_WIDTH-1], pos_y};
    assign ext_z = {pos_z[cmuv_pkg::COORD_WIDTH-1], pos_z};

    assign x_dom = (abs_x >= abs_y) && (abs_x >= abs_z);
    assign y_dom = (abs_y >= abs_x) && (abs_y >= abs_z);
    assign z_dom = (abs_z >= abs_x) && (abs_z >= abs_y);

    // Zero counts as negative.
    assign x_pos = !pos_x[cmuv_pkg::COORD_WIDTH-1] && (pos_x != '0);
    assign y_pos = !pos_y[cmuv_pkg::COORD_WIDTH-1] && (pos_y != '0);
    assign z_pos = !pos_z[cmuv_pkg::COORD_WIDTH-1] && (pos_z != '0);

    // Face selection: the Z test comes first and wins ties, then Y, then X.
    always_comb
    begin
        if (z_dom)
        begin
            max_mag = abs_z;
            uc      = z_pos ? ext_x : -ext_x;
            vc      = ext_y;
        end
        else if (y_dom)
        begin
            max_mag = abs_y;
            uc      = ext_x;
            vc      = y_pos ? -ext_z : ext_z;
        end
        else
        begin
            max_mag = abs_x;
            uc      = x_pos ? -ext_z : ext_z;
            vc      = ext_y;
        end
    end

    // Numerators uc + max and vc + max are never negative.
    assign num_u = {uc[cmuv_pkg::COORD_WIDTH], uc} + {2'b00, max_mag};
    assign num_v = {vc[cmuv_pkg::COORD_WIDTH], vc} + {2'b00, max_mag};

    // Payload for the first divider cell.
    always_comb
    begin
        data_next.mag   = max_mag;
        data_next.rem_u = num_u[cmuv_pkg::REM_WIDTH-1:0];
        data_next.rem_v = num_v[cmuv_pkg::REM_WIDTH-1:0];
        data_next.quo_u = '0;
        data_next.quo_v = '0;
        data_next.sat_u = (num_u[cmuv_pkg::REM_WIDTH-1:0] == {max_mag, 1'b0});
        data_next.sat_v = (num_v[cmuv_pkg::REM_WIDTH-1:0] == {max_mag, 1'b0});
        data_next.zero  = (pos_x == '0) && (pos_y == '0) && (pos_z == '0);
    end

    assign in_ready = !valid_reg || out_ready;

    // Pipeline register with stall.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // The origin is the only input with a zero dominant magnitude.
    a_zero_mag: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.zero == (data_reg.mag == '0)))
        else $error("zero flag disagrees with dominant magnitude");

endmodule

// ===== rtl/cmuv_cell.sv =====
module cmuv_cell
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  cmuv_pkg::stage_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output cmuv_pkg::stage_t out_data
);

    logic [cmuv_pkg::REM_WIDTH:0]   diff_u;
    logic [cmuv_pkg::REM_WIDTH:0]   diff_v;
    logic                           bit_u;
    logic                           bit_v;
    logic [cmuv_pkg::REM_WIDTH-1:0] keep_u;
    logic [cmuv_pkg::REM_WIDTH-1:0] keep_v;
    cmuv_pkg::stage_t               data_next;
    cmuv_pkg::stage_t               data_reg;
    logic                           valid_reg;

    // One restoring step per lane: trial subtract of the dominant magnitude.
    assign diff_u = {1'b0, in_data.rem_u} - {2'b00, in_data.mag};
    assign diff_v = {1'b0, in_data.rem_v} - {2'b00, in_data.mag};
    assign bit_u  = !diff_u[cmuv_pkg::REM_WIDTH];
    assign bit_v  = !diff_v[cmuv_pkg::REM_WIDTH];
    assign keep_u = bit_u ? diff_u[cmuv_pkg::REM_WIDTH-1:0] : in_data.rem_u;
    assign keep_v = bit_v ? diff_v[cmuv_pkg::REM_WIDTH-1:0] : in_data.rem_v;

    // The kept remainder is at most the magnitude, so doubling it fits.
    always_comb
    begin
        data_next       = in_data;
        data_next.rem_u = {keep_u[cmuv_pkg::COORD_WIDTH-1:0], 1'b0};
        data_next.rem_v = {keep_v[cmuv_pkg::COORD_WIDTH-1:0], 1'b0};
        data_next.quo_u = {in_data.quo_u[cmuv_pkg::UV_FRAC_BITS-2:0], bit_u};
        data_next.quo_v = {in_data.quo_v[cmuv_pkg::UV_FRAC_BITS-2:0], bit_v};
    end

    assign in_ready = !valid_reg || out_ready;

    // Pipeline register with stall.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // A stalled cell keeps its work.
    a_cell_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |=> valid_reg && $stable(data_reg))
        else $error("divider cell lost stalled work");

endmodule

// ===== verif/cube_map_uv_projection_chk.sv =====
module cube_map_uv_projection_chk
    import cmuv_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [S_TDATA_WIDTH-1:0] s_tdata,   // pos_x, pos_y, pos_z
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [M_TDATA_WIDTH-1:0] m_tdata,   // u_coord, v_coord
    input  logic                     m_tuser,   // zero_vector
    output int                       fail_count,
    output int                       pending_count
);

    localparam int REPORT_LIMIT = 10;

    // Cube faces in the order in which they are tested.
    typedef enum logic [2:0]
    {
        FACE_POS_X,
        FACE_NEG_X,
        FACE_POS_Y,
        FACE_NEG_Y,
        FACE_POS_Z,
        FACE_NEG_Z
    } face_e;

    typedef struct packed
    {
        logic [UV_FRAC_BITS-1:0] u_coord;
        logic [UV_FRAC_BITS-1:0] v_coord;
        logic                    zero_vector;
    } texcoord_t;

    texcoord_t texcoord_q[$];
    int        mismatch_total = 0;
    int        outstanding    = 0;

    assign fail_count    = mismatch_total;
    assign pending_count = outstanding;

    // Map an in-face coordinate in [-lim, lim] onto an unsigned fraction, full scale saturated.
    function automatic logic [UV_FRAC_BITS-1:0] scale_to_frac(input longint coord,
                                                              input longint lim);
        longint quot;
        quot = ((coord + lim) <<< UV_FRAC_BITS) / (2 * lim);
        if (quot > longint'(UV_TOP))
        begin
            quot = longint'(UV_TOP);
        end
        return quot[UV_FRAC_BITS-1:0];
    endfunction

    // Pick the face of one vertex and form its texture coordinate.
    function automatic texcoord_t project_vertex(input logic [S_TDATA_WIDTH-1:0] data);
        longint    px;
        longint    py;
        longint    pz;
        longint    ax;
        longint    ay;
        longint    az;
        longint    lim;
        longint    uc;
        longint    vc;
        bit        x_dom;
        bit        y_dom;
        bit        z_dom;
        face_e     face;
        texcoord_t res;
        px = longint'($signed(data[COORD_WIDTH-1:0]));
        py = longint'($signed(data[2*COORD_WIDTH-1:COORD_WIDTH]));
        pz = longint'($signed(data[3*COORD_WIDTH-1:2*COORD_WIDTH]));
        ax = (px < 0) ? -px : px;
        ay = (py < 0) ? -py : py;
        az = (pz < 0) ? -pz : pz;

        // The origin has no dominant axis and maps to the face center.
        if (px == 0 && py == 0 && pz == 0)
        begin
            res.u_coord     = UV_HALF;
            res.v_coord     = UV_HALF;
            res.zero_vector = 1'b1;
            return res;
        end

        // The last matching test wins, and a zero coordinate counts as negative.
        x_dom = (ax >= ay) && (ax >= az);
        y_dom = (ay >= ax) && (ay >= az);
        z_dom = (az >= ax) && (az >= ay);
        face  = FACE_POS_X;
        if (x_dom && px > 0)  face = FACE_POS_X;
        if (x_dom && px <= 0) face = FACE_NEG_X;
        if (y_dom && py > 0)  face = FACE_POS_Y;
        if (y_dom && py <= 0) face = FACE_NEG_Y;
        if (z_dom && pz > 0)  face = FACE_POS_Z;
        if (z_dom && pz <= 0) face = FACE_NEG_Z;

        case (face)
            FACE_POS_X: begin lim = ax; uc = -pz; vc = py;  end
            FACE_NEG_X: begin lim = ax; uc = pz;  vc = py;  end
            FACE_POS_Y: begin lim = ay; uc = px;  vc = -pz; end
            FACE_NEG_Y: begin lim = ay; uc = px;  vc = pz;  end
            FACE_POS_Z: begin lim = az; uc = px;  vc = py;  end
            default:    begin lim = az; uc = -px; vc = py;  end
        endcase

        res.u_coord     = scale_to_frac(uc, lim);
        res.v_coord     = scale_to_frac(vc, lim);
        res.zero_vector = 1'b0;
        return res;
    endfunction

    // Count a failure and describe the first few of them.
    task automatic note_failure(input string msg);
        mismatch_total++;
        if (mismatch_total <= REPORT_LIMIT)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // Predict on each input transfer and compare on each output transfer.
    always @(posedge clk)
    begin
        texcoord_t got;
        texcoord_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                texcoord_q = {texcoord_q, project_vertex(s_tdata)};
            end
            if (m_tvalid && m_tready)
            begin
                got.u_coord     = m_tdata[UV_FRAC_BITS-1:0];
                got.v_coord     = m_tdata[2*UV_FRAC_BITS-1:UV_FRAC_BITS];
                got.zero_vector = m_tuser;
                if (texcoord_q.size() == 0)
                begin
                    note_failure($sformatf("result u=%0d v=%0d zero=%0b with no vertex pending",
                                           got.u_coord, got.v_coord, got.zero_vector));
                end
                else
                begin
                    want = texcoord_q.pop_front();
                    if (got.u_coord !== want.u_coord || got.v_coord !== want.v_coord ||
                        got.zero_vector !== want.zero_vector)
                    begin
                        note_failure($sformatf(
                            "expected u=%0d v=%0d zero=%0b, got u=%0d v=%0d zero=%0b",
                            want.u_coord, want.v_coord, want.zero_vector,
                            got.u_coord, got.v_coord, got.zero_vector));
                    end
                end
            end
            outstanding = texcoord_q.size();
        end
    end

endmodule

// ===== verif/cube_map_uv_projection_tb.sv =====
module cube_map_uv_projection_tb;

    import cmuv_pkg::*;

    localparam int RANDOM_VERTICES = 1300;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int DRAIN_CYCLES    = 40;

    // Receiver stall patterns.
    localparam int STALL_NONE   = 0;
    localparam int STALL_RANDOM = 1;
    localparam int STALL_RARE   = 2;
    localparam int STALL_HEAVY  = 3;

    // Kinds of random vertex.
    localparam int VTX_FULL     = 0;
    localparam int VTX_SCALED   = 1;
    localparam int VTX_TINY     = 2;
    localparam int VTX_DOMINANT = 3;
    localparam int VTX_TIED     = 4;
    localparam int VTX_ZEROS    = 5;

    // Coordinate extremes.
    localparam logic [COORD_WIDTH-1:0] C_MAX  = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] C_MIN  = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic [COORD_WIDTH-1:0] C_NMAX = C_MIN + 1'b1;
    localparam logic [COORD_WIDTH-1:0] C_ZERO = '0;
    localparam logic [COORD_WIDTH-1:0] C_ONE  = COORD_WIDTH'(1);

    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [S_TDATA_WIDTH-1:0] s_tdata;   // pos_x, pos_y, pos_z
    logic                     m_tvalid;
    logic                     m_tready;
    logic [M_TDATA_WIDTH-1:0] m_tdata;   // u_coord, v_coord
    logic                     m_tuser;   // zero_vector

    int fail_count;
    int pending_count;
    int cycle_count = 0;
    int burst_left  = 1;
    bit valid_on    = 1'b0;

    cube_map_uv_projection u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    cube_map_uv_projection_chk u_chk
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: switches between stall patterns, each held for a random span.
    initial
    begin
        int stall_mode;
        int span;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall_mode = $urandom_range(STALL_NONE, STALL_HEAVY);
            span       = $urandom_range(20, 300);
            repeat (span)
            begin
                @(negedge clk);
                case (stall_mode)
                    STALL_NONE:   m_tready <= 1'b1;
                    STALL_RANDOM: m_tready <= 1'($urandom_range(0, 1));
                    STALL_RARE:   m_tready <= ($urandom_range(0, 9) != 0);
                    default:      m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Send one vertex in a burst; entered and left at a falling edge.
    task automatic send_vertex(input logic [COORD_WIDTH-1:0] px,
                               input logic [COORD_WIDTH-1:0] py,
                               input logic [COORD_WIDTH-1:0] pz);
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_WIDTH'({pz, py, px});
        valid_on  = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            s_tvalid <= 1'b0;
            valid_on  = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 20);
        end
    endtask

    // Hold the sender off until every pending result has been delivered.
    task automatic wait_for_drain();
        if (valid_on)
        begin
            s_tvalid <= 1'b0;
            valid_on  = 1'b0;
            @(negedge clk);
        end
        while (pending_count != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Draw a random vertex from a mix of shapes that reach ties, saturation and the origin.
    task automatic make_vertex(output logic [COORD_WIDTH-1:0] px,
                               output logic [COORD_WIDTH-1:0] py,
                               output logic [COORD_WIDTH-1:0] pz);
        int                     kind;
        int                     axis;
        int                     lim;
        logic [COORD_WIDTH-1:0] c [3];
        kind = $urandom_range(0, 9);
        axis = $urandom_range(0, 2);
        lim  = int'($urandom_range(1, 8388607) >> $urandom_range(0, 22));
        if (lim == 0)
        begin
            lim = 1;
        end
        if (kind <= 1)
        begin
            kind = VTX_FULL;
        end
        else if (kind <= 5)
        begin
            kind = kind - 1;
        end
        else if (kind <= 7)
        begin
            kind = VTX_DOMINANT;
        end
        else
        begin
            kind = VTX_TIED;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            kind = VTX_ZEROS;
        end
        for (int i = 0; i < 3; i++)
        begin
            case (kind)
                VTX_FULL:   c[i] = COORD_WIDTH'($urandom);
                VTX_SCALED: c[i] = COORD_WIDTH'(int'($urandom) >>> $urandom_range(0, 23));
                VTX_TINY:   c[i] = COORD_WIDTH'(int'($urandom_range(0, 16)) - 8);
                VTX_TIED:
                begin
                    case ($urandom_range(0, 2))
                        0:       c[i] = COORD_WIDTH'(lim);
                        1:       c[i] = COORD_WIDTH'(-lim);
                        default: c[i] = COORD_WIDTH'(int'($urandom_range(0, 2 * lim)) - lim);
                    endcase
                end
                VTX_ZEROS:  c[i] = $urandom_range(0, 1) ? C_ZERO : COORD_WIDTH'($urandom);
                default:    c[i] = COORD_WIDTH'(int'($urandom_range(0, 2 * lim)) - lim);
            endcase
        end
        // A dominant vertex carries the full magnitude on one axis.
        if (kind == VTX_DOMINANT)
        begin
            c[axis] = $urandom_range(0, 1) ? COORD_WIDTH'(lim) : COORD_WIDTH'(-lim);
        end
        px = c[0];
        py = c[1];
        pz = c[2];
    endtask

    // Reset, directed vertices, random vertices, then the verdict.
    initial
    begin
        logic [COORD_WIDTH-1:0] px;
        logic [COORD_WIDTH-1:0] py;
        logic [COORD_WIDTH-1:0] pz;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Origin, each face at full scale, and the most negative code on each axis.
        send_vertex(C_ZERO, C_ZERO, C_ZERO);
        send_vertex(C_MAX, C_ZERO, C_ZERO);
        send_vertex(C_NMAX, C_ZERO, C_ZERO);
        send_vertex(C_ZERO, C_MAX, C_ZERO);
        send_vertex(C_ZERO, C_NMAX, C_ZERO);
        send_vertex(C_ZERO, C_ZERO, C_MAX);
        send_vertex(C_ZERO, C_ZERO, C_NMAX);
        send_vertex(C_MIN, C_ZERO, C_ZERO);
        send_vertex(C_ZERO, C_MIN, C_ZERO);
        send_vertex(C_ZERO, C_ZERO, C_MIN);

        // Ties between axes, where the later face wins, and full-scale saturation.
        send_vertex(C_MAX, C_MAX, C_MAX);
        send_vertex(C_NMAX, C_NMAX, C_NMAX);
        send_vertex(C_MIN, C_MIN, C_MIN);
        send_vertex(C_MAX, C_MAX, C_NMAX);
        send_vertex(C_MAX, C_NMAX, C_ZERO);
        send_vertex(C_ONE, C_ONE, C_ZERO);
        send_vertex(COORD_WIDTH'(7), COORD_WIDTH'(-7), C_ZERO);
        send_vertex(COORD_WIDTH'(3), COORD_WIDTH'(-5), COORD_WIDTH'(5));
        send_vertex(COORD_WIDTH'(-4), COORD_WIDTH'(4), COORD_WIDTH'(-4));

        // Smallest magnitudes, near-ties and alternating bit patterns.
        send_vertex(C_ONE, C_ZERO, C_ZERO);
        send_vertex(COORD_WIDTH'(-1), C_ZERO, C_ZERO);
        send_vertex(C_MAX, C_MAX - 1'b1, C_MIN);
        send_vertex(C_MIN, C_MAX, C_ONE);
        send_vertex(24'h555555, 24'hAAAAAA, 24'h0F0F0F);
        send_vertex(24'hAAAAAA, 24'h555555, 24'hF0F0F0);

        // Let the pipeline empty completely once before the random part.
        wait_for_drain();

        for (int n = 0; n < RANDOM_VERTICES; n++)
        begin
            make_vertex(px, py, pz);
            send_vertex(px, py, pz);
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/cmuv_pkg.sv
rtl/cmuv_front.sv
rtl/cmuv_cell.sv
rtl/cube_map_uv_projection.sv
verif/cube_map_uv_projection_chk.sv
verif/cube_map_uv_projection_tb.sv
